// ----- src/sdp_pkg.sv -----
// ----------------------------------------------------------------------------
// SPS dimension parser package
// Shared types and constants for the parameter set dimension parser.
// ----------------------------------------------------------------------------
package sdp_pkg;

  localparam int unsigned MaxZeroRun = 31;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  localparam logic [1:0] STATUS_COMPLETE  = 2'd0;
  localparam logic [1:0] STATUS_EARLY_END = 2'd1;
  localparam logic [1:0] STATUS_MALFORMED = 2'd2;

  localparam logic [2:0] REG_EXP_WIDTH   = 3'd0;
  localparam logic [2:0] REG_EXP_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_EXP_PROFILE = 3'd2;
  localparam logic [2:0] REG_LOW_LEVEL   = 3'd3;
  localparam logic [2:0] REG_HIGH_LEVEL  = 3'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [7:0]  profile_code;
    logic [7:0]  level_code;
    logic [1:0]  parse_status;
    logic        meets_limits;
  } result_t;

  typedef struct packed {
    logic [15:0] exp_width;
    logic [15:0] exp_height;
    logic [7:0]  exp_profile;
    logic [7:0]  low_level;
    logic [7:0]  high_level;
  } limits_t;

endpackage

// ----- src/h264_sps_dimension_parser_unit.sv -----
// ----------------------------------------------------------------------------
// H.264 SPS dimension parser
// Reads picture size, profile and level from parameter set payload bytes.
// ----------------------------------------------------------------------------
// Payload bytes enter a four-entry queue and are taken by a bit parser that
// consumes one syntax bit per cycle while it walks a payload byte; a header
// byte (profile, constraint flags, level) is taken whole. Each parameter set
// gives one result, held in a one-entry output register until it is popped.
module h264_sps_dimension_parser_unit #(
  parameter int unsigned MAX_ZERO_RUN = sdp_pkg::MaxZeroRun
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  payload_byte,
  input  logic        final_byte,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] frame_width,
  output logic [15:0] frame_height,
  output logic [7:0]  profile_code,
  output logic [7:0]  level_code,
  output logic [1:0]  parse_status,
  output logic        meets_limits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  sdp_pkg::byte_item_t wr_item;
  sdp_pkg::byte_item_t rd_item;
  sdp_pkg::result_t    new_result;
  sdp_pkg::result_t    held;
  sdp_pkg::limits_t    limits;
  logic rd_valid;
  logic rd_pop;
  logic out_valid;
  logic out_write;

  assign wr_item.data = payload_byte;
  assign wr_item.last = final_byte;
  assign cfg_ready    = 1'b1;

  sdp_byte_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_item  (wr_item),
    .full     (full),
    .rd_pop   (rd_pop),
    .rd_valid (rd_valid),
    .rd_item  (rd_item)
  );

  sdp_bit_parser #(.MAX_ZERO_RUN(MAX_ZERO_RUN)) u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rd_valid),
    .in_item    (rd_item),
    .in_pop     (rd_pop),
    .limits     (limits),
    .out_full   (out_valid),
    .out_write  (out_write),
    .out_result (new_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.exp_width   <= 16'd1920;
      limits.exp_height  <= 16'd1080;
      limits.exp_profile <= 8'd100;
      limits.low_level   <= 8'd0;
      limits.high_level  <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sdp_pkg::REG_EXP_WIDTH:   limits.exp_width   <= cfg_data;
        sdp_pkg::REG_EXP_HEIGHT:  limits.exp_height  <= cfg_data;
        sdp_pkg::REG_EXP_PROFILE: limits.exp_profile <= cfg_data[7:0];
        sdp_pkg::REG_LOW_LEVEL:   limits.low_level   <= cfg_data[7:0];
        sdp_pkg::REG_HIGH_LEVEL:  limits.high_level  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_write) held <= new_result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_write) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty        = !out_valid;
  assign frame_width  = held.frame_width;
  assign frame_height = held.frame_height;
  assign profile_code = held.profile_code;
  assign level_code   = held.level_code;
  assign parse_status = held.parse_status;
  assign meets_limits = held.meets_limits;

endmodule

// ----- src/sdp_byte_queue.sv -----
// ----------------------------------------------------------------------------
// SPS byte queue
// Short queue of payload bytes between the input side and the bit parser.
// ----------------------------------------------------------------------------
module sdp_byte_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sdp_pkg::byte_item_t wr_item,
  output logic               full,
  input  logic               rd_pop,
  output logic               rd_valid,
  output sdp_pkg::byte_item_t rd_item
);

  sdp_pkg::byte_item_t entries [sdp_pkg::QueueDepth];
  logic [sdp_pkg::QueuePtrW-1:0] wr_ptr;
  logic [sdp_pkg::QueuePtrW-1:0] rd_ptr;
  logic [sdp_pkg::QueuePtrW:0]   count;
  logic do_wr;
  logic do_rd;

  assign full     = (count == (sdp_pkg::QueuePtrW+1)'(sdp_pkg::QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_item  = entries[rd_ptr];
  assign do_wr    = push && !full;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    full |=> !(count == '0))
    else $error("queue lost entries while full");

  assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a lone write");

  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers differ while empty");

endmodule

// ----- src/sdp_bit_parser.sv -----
// ----------------------------------------------------------------------------
// SPS bit parser
// Walks the parameter set syntax one bit per cycle and builds the result.
// ----------------------------------------------------------------------------
module sdp_bit_parser #(
  parameter int unsigned MAX_ZERO_RUN = sdp_pkg::MaxZeroRun
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  sdp_pkg::byte_item_t in_item,
  output logic                in_pop,
  input  sdp_pkg::limits_t    limits,
  input  logic                out_full,
  output logic                out_write,
  output sdp_pkg::result_t    out_result
);

  typedef enum logic [1:0] {S_IDLE, S_BITS, S_FINISH} state_t;

  typedef enum logic [4:0] {
    PH_HEADER, PH_SPS_ID, PH_CHROMA, PH_SEP_PLANE, PH_BD_LUMA, PH_BD_CHROMA,
    PH_BYPASS, PH_SCALE_FLAG, PH_SCALE_SKIP, PH_LOG2_FN, PH_POC_TYPE,
    PH_POC_LSB, PH_DELTA_FLAG, PH_OFF_NONREF, PH_OFF_T2B, PH_NUM_CYCLE,
    PH_CYCLE_OFFS, PH_MAX_REF, PH_GAPS, PH_WIDTH, PH_HEIGHT, PH_MBS_ONLY,
    PH_MBAFF, PH_DIRECT8, PH_CROP_FLAG, PH_CROP_L, PH_CROP_R, PH_CROP_T,
    PH_CROP_B, PH_DONE
  } phase_t;

  state_t      state;
  phase_t      phase;
  logic [1:0]  hdr_cnt;
  logic [7:0]  shreg;
  logic [2:0]  bit_cnt;
  logic        last_r;
  logic        emit_r;
  logic [5:0]  zero_run;
  logic [31:0] code_value;
  logic [5:0]  code_left;
  logic [7:0]  profile;
  logic [7:0]  level;
  logic [31:0] cyc;
  logic        field;
  logic [15:0] wacc;
  logic [15:0] hacc;
  logic        given;
  logic [1:0]  status;

  logic        b;
  logic        code_phase;
  logic [31:0] cv_shift;
  logic [31:0] val;
  logic        take_now;
  logic        stop_now;
  logic        emit_now;
  logic [1:0]  stat_sel;
  logic        ok;

  assign b          = shreg[7];
  assign cv_shift   = {code_value[30:0], b};
  assign take_now   = (code_left == 6'd1) || (code_left == '0 && b && zero_run == '0);
  assign val        = (code_left == '0) ? 32'd0 : ((32'd1 << zero_run) - 32'd1 + cv_shift);
  assign code_phase = (phase inside {PH_SPS_ID, PH_CHROMA, PH_BD_LUMA, PH_BD_CHROMA,
                        PH_LOG2_FN, PH_POC_TYPE, PH_POC_LSB, PH_OFF_NONREF, PH_OFF_T2B,
                        PH_NUM_CYCLE, PH_CYCLE_OFFS, PH_MAX_REF, PH_WIDTH, PH_HEIGHT,
                        PH_CROP_L, PH_CROP_R, PH_CROP_T, PH_CROP_B});
  assign stop_now   = code_phase
                      ? ((code_left == '0 && !b && (zero_run + 6'd1 > 6'(MAX_ZERO_RUN)))
                         || (take_now && phase == PH_CROP_B))
                      : (phase == PH_CROP_FLAG && !b);

  assign emit_now  = emit_r || (last_r && !given);
  assign stat_sel  = emit_r ? status : sdp_pkg::STATUS_EARLY_END;
  assign ok        = (stat_sel == sdp_pkg::STATUS_COMPLETE);
  assign in_pop    = (state == S_IDLE) && in_valid;
  assign out_write = (state == S_FINISH) && emit_now && !out_full;

  always_comb begin
    out_result.frame_width  = ok ? wacc : 16'd0;
    out_result.frame_height = ok ? hacc : 16'd0;
    out_result.profile_code = profile;
    out_result.level_code   = level;
    out_result.parse_status = stat_sel;
    out_result.meets_limits = ok && wacc == limits.exp_width && hacc == limits.exp_height
                              && profile == limits.exp_profile && level >= limits.low_level
                              && level <= limits.high_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_HEADER;
      hdr_cnt    <= '0;
      shreg      <= '0;
      bit_cnt    <= '0;
      last_r     <= 1'b0;
      emit_r     <= 1'b0;
      zero_run   <= '0;
      code_value <= '0;
      code_left  <= '0;
      profile    <= '0;
      level      <= '0;
      cyc        <= '0;
      field      <= 1'b0;
      wacc       <= '0;
      hacc       <= '0;
      given      <= 1'b0;
      status     <= sdp_pkg::STATUS_COMPLETE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_r  <= in_item.last;
            emit_r  <= 1'b0;
            shreg   <= in_item.data;
            bit_cnt <= '0;
            if (given) begin
              state <= S_FINISH;
            end else if (phase == PH_HEADER) begin
              if (hdr_cnt == 2'd0) profile <= in_item.data;
              if (hdr_cnt == 2'd2) begin
                level   <= in_item.data;
                hdr_cnt <= '0;
                phase   <= PH_SPS_ID;
              end else begin
                hdr_cnt <= hdr_cnt + 2'd1;
              end
              state <= S_FINISH;
            end else begin
              state <= S_BITS;
            end
          end
        end
        S_BITS: begin
          shreg   <= {shreg[6:0], 1'b0};
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7 || stop_now) state <= S_FINISH;
          if (code_phase) begin
            if (code_left != '0) begin
              code_value <= (code_left == 6'd1) ? '0 : cv_shift;
              code_left  <= code_left - 6'd1;
            end else if (b && zero_run != '0) begin
              code_left  <= zero_run;
              code_value <= '0;
            end else if (!b) begin
              zero_run <= zero_run + 6'd1;
              if (zero_run + 6'd1 > 6'(MAX_ZERO_RUN)) begin
                given  <= 1'b1;
                emit_r <= 1'b1;
                status <= sdp_pkg::STATUS_MALFORMED;
                phase  <= PH_DONE;
              end
            end
            if (take_now) begin
              zero_run <= '0;
              case (phase)
                PH_SPS_ID: phase <= (profile >= 8'd100) ? PH_CHROMA : PH_LOG2_FN;
                PH_CHROMA: phase <= (val == 32'd3) ? PH_SEP_PLANE : PH_BD_LUMA;
                PH_BD_LUMA: phase <= PH_BD_CHROMA;
                PH_BD_CHROMA: phase <= PH_BYPASS;
                PH_LOG2_FN: phase <= PH_POC_TYPE;
                PH_POC_TYPE: begin
                  phase <= (val == 32'd0) ? PH_POC_LSB
                         : ((val == 32'd1) ? PH_DELTA_FLAG : PH_MAX_REF);
                end
                PH_POC_LSB: phase <= PH_MAX_REF;
                PH_OFF_NONREF: phase <= PH_OFF_T2B;
                PH_OFF_T2B: phase <= PH_NUM_CYCLE;
                PH_NUM_CYCLE: begin
                  cyc   <= val;
                  phase <= (val != 32'd0) ? PH_CYCLE_OFFS : PH_MAX_REF;
                end
                PH_CYCLE_OFFS: begin
                  cyc <= cyc - 32'd1;
                  if (cyc == 32'd1) phase <= PH_MAX_REF;
                end
                PH_MAX_REF: phase <= PH_GAPS;
                PH_WIDTH: begin
                  wacc  <= {val[11:0] + 12'd1, 4'd0};
                  phase <= PH_HEIGHT;
                end
                PH_HEIGHT: begin
                  hacc  <= val[15:0] + 16'd1;
                  phase <= PH_MBS_ONLY;
                end
                PH_CROP_L: begin
                  wacc  <= wacc - {val[14:0], 1'b0};
                  phase <= PH_CROP_R;
                end
                PH_CROP_R: begin
                  wacc  <= wacc - {val[14:0], 1'b0};
                  phase <= PH_CROP_T;
                end
                PH_CROP_T: begin
                  hacc  <= hacc - (field ? {val[13:0], 2'd0} : {val[14:0], 1'b0});
                  phase <= PH_CROP_B;
                end
                PH_CROP_B: begin
                  hacc   <= hacc - (field ? {val[13:0], 2'd0} : {val[14:0], 1'b0});
                  given  <= 1'b1;
                  emit_r <= 1'b1;
                  status <= sdp_pkg::STATUS_COMPLETE;
                  phase  <= PH_DONE;
                end
                default: ;
              endcase
            end
          end else begin
            case (phase)
              PH_SEP_PLANE: phase <= PH_BD_LUMA;
              PH_BYPASS: phase <= PH_SCALE_FLAG;
              PH_SCALE_FLAG: begin
                if (b) begin
                  cyc   <= 32'd8;
                  phase <= PH_SCALE_SKIP;
                end else begin
                  phase <= PH_LOG2_FN;
                end
              end
              PH_SCALE_SKIP: begin
                cyc <= cyc - 32'd1;
                if (cyc == 32'd1) phase <= PH_LOG2_FN;
              end
              PH_DELTA_FLAG: phase <= PH_OFF_NONREF;
              PH_GAPS: phase <= PH_WIDTH;
              PH_MBS_ONLY: begin
                field <= !b;
                hacc  <= b ? {hacc[11:0], 4'd0} : {hacc[10:0], 5'd0};
                phase <= b ? PH_DIRECT8 : PH_MBAFF;
              end
              PH_MBAFF: phase <= PH_DIRECT8;
              PH_DIRECT8: phase <= PH_CROP_FLAG;
              PH_CROP_FLAG: begin
                if (b) begin
                  phase <= PH_CROP_L;
                end else begin
                  given  <= 1'b1;
                  emit_r <= 1'b1;
                  status <= sdp_pkg::STATUS_COMPLETE;
                  phase  <= PH_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        S_FINISH: begin
          if (!(emit_now && out_full)) begin
            state <= S_IDLE;
            if (last_r) begin
              phase      <= PH_HEADER;
              hdr_cnt    <= '0;
              zero_run   <= '0;
              code_value <= '0;
              code_left  <= '0;
              profile    <= '0;
              level      <= '0;
              cyc        <= '0;
              field      <= 1'b0;
              wacc       <= '0;
              hacc       <= '0;
              given      <= 1'b0;
            end else if (emit_now) begin
              given <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_write |-> !out_full)
    else $error("result written while output slot is occupied");

  assert property (@(posedge clk) disable iff (rst)
    !given |-> (zero_run <= 6'(MAX_ZERO_RUN)))
    else $error("zero run went past its limit");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_BITS) |-> !given)
    else $error("bits walked after a result was given");

endmodule

// ----- bench/tb_h264_sps_dimension_parser_unit.sv -----
// ----------------------------------------------------------------------------
// Testbench for the H.264 SPS dimension parser
// Builds parameter set payloads (well-formed, cut short, with overlong
// Exp-Golomb prefixes, and random noise), streams them through the byte
// queue and compares every popped result against a bit-level predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_h264_sps_dimension_parser_unit;
  import sdp_pkg::*;

  typedef enum logic [4:0] {
    PH_HEADER, PH_SPS_ID, PH_CHROMA, PH_SEP_PLANE, PH_BD_LUMA, PH_BD_CHROMA,
    PH_BYPASS, PH_SCALE_FLAG, PH_SCALE_SKIP, PH_LOG2_FN, PH_POC_TYPE, PH_POC_LSB,
    PH_DELTA_FLAG, PH_OFF_NONREF, PH_OFF_T2B, PH_NUM_CYCLE, PH_CYCLE_OFFS,
    PH_MAX_REF, PH_GAPS, PH_WIDTH, PH_HEIGHT, PH_MBS_ONLY, PH_MBAFF, PH_DIRECT8,
    PH_CROP_FLAG, PH_CROP_L, PH_CROP_R, PH_CROP_T, PH_CROP_B, PH_DONE
  } sps_phase_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  payload_byte = '0;
  logic        final_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] frame_width;
  logic [15:0] frame_height;
  logic [7:0]  profile_code;
  logic [7:0]  level_code;
  logic [1:0]  parse_status;
  logic        meets_limits;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  h264_sps_dimension_parser_unit dut (.*);

  always #10 clk = ~clk;

  // Limits mirrored from the register writes.
  limits_t lim;

  // Predictor state.
  sps_phase_e  ph;
  logic [1:0]  hdr_count;
  logic [5:0]  zrun;
  logic [31:0] code_val;
  logic [5:0]  code_left;
  logic [7:0]  prof;
  logic [7:0]  lvl;
  logic [31:0] cyc_count;
  logic        field_mode;
  logic [15:0] w_acc;
  logic [15:0] h_acc;
  logic        done_flag;
  logic [1:0]  done_status;

  result_t     expected_results[$];
  byte_item_t  pending_bytes[$];
  int          send_idle = 0;
  int          recv_idle = 0;
  int          mismatches = 0;
  bit          gen_bits[$];

  function automatic void clear_sps();
    ph = PH_HEADER; hdr_count = '0; zrun = '0; code_val = '0; code_left = '0;
    prof = '0; lvl = '0; cyc_count = '0; field_mode = 1'b0;
    w_acc = '0; h_acc = '0; done_flag = 1'b0;
  endfunction

  function automatic void finish_sps(logic [1:0] st);
    done_flag = 1'b1;
    done_status = st;
    ph = PH_DONE;
  endfunction

  function automatic void take_value(logic [31:0] v);
    logic [15:0] unit;
    unit = field_mode ? 16'd4 : 16'd2;
    case (ph)
      PH_SPS_ID:     ph = (prof >= 8'd100) ? PH_CHROMA : PH_LOG2_FN;
      PH_CHROMA:     ph = (v == 32'd3) ? PH_SEP_PLANE : PH_BD_LUMA;
      PH_BD_LUMA:    ph = PH_BD_CHROMA;
      PH_BD_CHROMA:  ph = PH_BYPASS;
      PH_LOG2_FN:    ph = PH_POC_TYPE;
      PH_POC_TYPE:   ph = (v == 0) ? PH_POC_LSB : ((v == 1) ? PH_DELTA_FLAG : PH_MAX_REF);
      PH_POC_LSB:    ph = PH_MAX_REF;
      PH_OFF_NONREF: ph = PH_OFF_T2B;
      PH_OFF_T2B:    ph = PH_NUM_CYCLE;
      PH_NUM_CYCLE: begin
        cyc_count = v;
        ph = (v != 0) ? PH_CYCLE_OFFS : PH_MAX_REF;
      end
      PH_CYCLE_OFFS: begin
        cyc_count = cyc_count - 1;
        if (cyc_count == 0) ph = PH_MAX_REF;
      end
      PH_MAX_REF:    ph = PH_GAPS;
      PH_WIDTH: begin
        w_acc = 16'((v + 32'd1) * 32'd16);
        ph = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        h_acc = 16'(v + 32'd1);
        ph = PH_MBS_ONLY;
      end
      PH_CROP_L: begin w_acc = w_acc - 16'(v * 2); ph = PH_CROP_R; end
      PH_CROP_R: begin w_acc = w_acc - 16'(v * 2); ph = PH_CROP_T; end
      PH_CROP_T: begin h_acc = h_acc - 16'(v * unit); ph = PH_CROP_B; end
      PH_CROP_B: begin
        h_acc = h_acc - 16'(v * unit);
        finish_sps(STATUS_COMPLETE);
      end
      default: ;
    endcase
  endfunction

  function automatic void take_flag(logic b);
    case (ph)
      PH_SEP_PLANE:  ph = PH_BD_LUMA;
      PH_BYPASS:     ph = PH_SCALE_FLAG;
      PH_SCALE_FLAG: begin
        if (b) begin
          cyc_count = 32'd8;
          ph = PH_SCALE_SKIP;
        end else begin
          ph = PH_LOG2_FN;
        end
      end
      PH_SCALE_SKIP: begin
        cyc_count = cyc_count - 1;
        if (cyc_count == 0) ph = PH_LOG2_FN;
      end
      PH_DELTA_FLAG: ph = PH_OFF_NONREF;
      PH_GAPS:       ph = PH_WIDTH;
      PH_MBS_ONLY: begin
        field_mode = ~b;
        h_acc = 16'(h_acc * (b ? 16'd16 : 16'd32));
        ph = b ? PH_DIRECT8 : PH_MBAFF;
      end
      PH_MBAFF:      ph = PH_DIRECT8;
      PH_DIRECT8:    ph = PH_CROP_FLAG;
      PH_CROP_FLAG: begin
        if (b) ph = PH_CROP_L;
        else finish_sps(STATUS_COMPLETE);
      end
      default: ;
    endcase
  endfunction

  function automatic void take_bit(logic b);
    if (!(ph inside {PH_SPS_ID, PH_CHROMA, PH_BD_LUMA, PH_BD_CHROMA, PH_LOG2_FN,
                     PH_POC_TYPE, PH_POC_LSB, PH_OFF_NONREF, PH_OFF_T2B, PH_NUM_CYCLE,
                     PH_CYCLE_OFFS, PH_MAX_REF, PH_WIDTH, PH_HEIGHT, PH_CROP_L,
                     PH_CROP_R, PH_CROP_T, PH_CROP_B})) begin
      take_flag(b);
    end else if (code_left != 0) begin
      code_val = {code_val[30:0], b};
      code_left = code_left - 1;
      if (code_left == 0) begin
        logic [31:0] v;
        v = (32'd1 << zrun) - 32'd1 + code_val;
        zrun = '0;
        code_val = '0;
        take_value(v);
      end
    end else if (b) begin
      if (zrun == 0) begin
        take_value(32'd0);
      end else begin
        code_left = zrun;
        code_val = '0;
      end
    end else begin
      zrun = zrun + 1;
      if (zrun > MaxZeroRun) finish_sps(STATUS_MALFORMED);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] d, logic last);
    result_t r;
    logic had;
    had = done_flag;
    if (!had) begin
      if (ph == PH_HEADER) begin
        if (hdr_count == 0) prof = d;
        else if (hdr_count == 2) lvl = d;
        hdr_count = hdr_count + 1;
        if (hdr_count == 3) begin
          hdr_count = '0;
          ph = PH_SPS_ID;
        end
      end else begin
        for (int k = 7; k >= 0; k--) begin
          if (!done_flag) take_bit(d[k]);
        end
      end
      if (last && !done_flag) finish_sps(STATUS_EARLY_END);
    end
    if (!had && done_flag) begin
      r.frame_width  = (done_status == STATUS_COMPLETE) ? w_acc : 16'd0;
      r.frame_height = (done_status == STATUS_COMPLETE) ? h_acc : 16'd0;
      r.profile_code = prof;
      r.level_code   = lvl;
      r.parse_status = done_status;
      r.meets_limits = (done_status == STATUS_COMPLETE) && w_acc == lim.exp_width &&
                       h_acc == lim.exp_height && prof == lim.exp_profile &&
                       lvl >= lim.low_level && lvl <= lim.high_level;
      expected_results.push_back(r);
    end
    if (last) clear_sps();
  endfunction

  // Byte driver.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) predict_byte(payload_byte, final_byte);
      if (!push || !full) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle) begin
          byte_item_t it;
          it = pending_bytes.pop_front();
          push <= 1'b1;
          payload_byte <= it.data;
          final_byte <= it.last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
        end else begin
          result_t e;
          result_t a;
          e = expected_results.pop_front();
          a = '{frame_width, frame_height, profile_code, level_code, parse_status,
                meets_limits};
          if (a !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected w=%0d h=%0d p=%0d l=%0d s=%0d m=%0d, got w=%0d h=%0d p=%0d l=%0d s=%0d m=%0d",
                       e.frame_width, e.frame_height, e.profile_code, e.level_code,
                       e.parse_status, e.meets_limits, a.frame_width, a.frame_height,
                       a.profile_code, a.level_code, a.parse_status, a.meets_limits);
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_EXP_WIDTH:   lim.exp_width = val;
      REG_EXP_HEIGHT:  lim.exp_height = val;
      REG_EXP_PROFILE: lim.exp_profile = val[7:0];
      REG_LOW_LEVEL:   lim.low_level = val[7:0];
      REG_HIGH_LEVEL:  lim.high_level = val[7:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || push || expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic void put_bits(longint unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) gen_bits.push_back(v[i]);
  endfunction

  function automatic void put_ue(longint unsigned v);
    longint unsigned x;
    int msb;
    x = v + 1;
    msb = 0;
    for (int i = 0; i < 40; i++) if (x[i]) msb = i;
    put_bits(0, msb);
    put_bits(x, msb + 1);
  endfunction

  function automatic void push_bytes(byte_item_t items[$]);
    foreach (items[i]) pending_bytes.push_back(items[i]);
  endfunction

  // Kind 0: well-formed, 1: cut short, 2: overlong prefix, 3: matching the limits.
  function automatic void queue_sps(int kind);
    byte_item_t items[$];
    logic [7:0] p;
    int poc;
    int nbytes;
    int wm1;
    int hm1;
    int crop_r;
    int crop_b;
    gen_bits.delete();
    if (kind == 3) p = lim.exp_profile;
    else begin
      case ($urandom_range(5))
        0: p = 8'd66;
        1: p = 8'd77;
        2: p = 8'd100;
        3: p = 8'd244;
        default: p = 8'($urandom);
      endcase
    end
    put_bits(p, 8);
    put_bits($urandom, 8);
    if (kind == 3) put_bits($urandom_range(lim.high_level, lim.low_level), 8);
    else put_bits($urandom, 8);
    put_ue($urandom_range(31));
    if (p >= 100) begin
      logic [1:0] ch;
      ch = 2'($urandom_range(3));
      put_ue(ch);
      if (ch == 3) put_bits($urandom_range(1), 1);
      put_ue($urandom_range(6));
      put_ue($urandom_range(6));
      put_bits($urandom_range(1), 1);
      if ($urandom_range(1)) begin
        put_bits(1, 1);
        put_bits($urandom, 8);
      end else put_bits(0, 1);
    end
    put_ue($urandom_range(12));
    poc = $urandom_range(3);
    if (poc == 3) poc = $urandom_range(200, 2);
    put_ue(poc);
    if (poc == 0) put_ue($urandom_range(12));
    else if (poc == 1) begin
      int n;
      put_bits($urandom_range(1), 1);
      put_ue($urandom_range(300));
      put_ue($urandom_range(300));
      n = $urandom_range(4);
      put_ue(n);
      for (int i = 0; i < n; i++) put_ue($urandom_range(100));
    end
    put_ue($urandom_range(16));
    put_bits($urandom_range(1), 1);
    if (kind == 3) begin
      wm1 = (lim.exp_width == 0) ? 4095 : (lim.exp_width + 15) / 16 - 1;
      hm1 = (lim.exp_height == 0) ? 4095 : (lim.exp_height + 15) / 16 - 1;
      crop_r = (((wm1 + 1) * 16) % 65536 - lim.exp_width) / 2;
      crop_b = (((hm1 + 1) * 16) % 65536 - lim.exp_height) / 2;
      put_ue(wm1);
      put_ue(hm1);
      put_bits(1, 1);
      put_bits($urandom_range(1), 1);
      put_bits(1, 1);
      put_ue(0);
      put_ue(crop_r < 0 ? 0 : crop_r);
      put_ue(0);
      put_ue(crop_b < 0 ? 0 : crop_b);
    end else begin
      logic mbs;
      put_ue($urandom_range(3) == 0 ? $urandom_range(70000) : $urandom_range(130));
      put_ue($urandom_range(3) == 0 ? $urandom_range(70000) : $urandom_range(80));
      mbs = $urandom_range(1);
      put_bits(mbs, 1);
      if (!mbs) put_bits($urandom_range(1), 1);
      put_bits($urandom_range(1), 1);
      if ($urandom_range(1)) begin
        put_bits(1, 1);
        for (int i = 0; i < 4; i++)
          put_ue($urandom_range(7) == 0 ? $urandom_range(40000) : $urandom_range(20));
      end else put_bits(0, 1);
    end
    if (kind == 2) begin
      int at;
      at = $urandom_range(gen_bits.size() - 1, 24);
      for (int i = 0; i < $urandom_range(40, 32); i++) gen_bits.insert(at, 1'b0);
    end
    while (gen_bits.size() % 8 != 0) gen_bits.push_back($urandom_range(1));
    nbytes = gen_bits.size() / 8 + $urandom_range(2);
    if (kind == 1) nbytes = $urandom_range(gen_bits.size() / 8 - 1, 1);
    for (int i = 0; i < nbytes; i++) begin
      byte_item_t it;
      for (int k = 0; k < 8; k++)
        it.data[7 - k] = (i * 8 + k < gen_bits.size()) ? gen_bits[i * 8 + k] : $urandom_range(1);
      it.last = (i == nbytes - 1);
      items.push_back(it);
    end
    push_bytes(items);
  endfunction

  task automatic run_phase(int count);
    while (count > 0) begin
      int sel;
      int before_size;
      before_size = pending_bytes.size();
      sel = $urandom_range(99);
      if (sel < 50) queue_sps(0);
      else if (sel < 70) queue_sps(3);
      else if (sel < 80) queue_sps(1);
      else if (sel < 88) queue_sps(2);
      else begin
        for (int i = 0; i < $urandom_range(12, 1); i++)
          pending_bytes.push_back('{data: 8'($urandom), last: ($urandom_range(7) == 0)});
        pending_bytes.push_back('{data: 8'($urandom), last: 1'b1});
      end
      count -= pending_bytes.size() - before_size;
      while (pending_bytes.size() > 8) @(posedge clk);
    end
  endtask

  initial begin
    byte_item_t d[$];
    lim = '{16'd1920, 16'd1080, 8'd100, 8'd0, 8'd255};
    clear_sps();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: a lone final byte, a header only, a run of zeros, all ones,
    // a maximal poc cycle count cut short, and a 1920x1080 stream that matches.
    d = '{'{8'hFF, 1'b1}, '{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{8'h80, 1'b1},
          '{8'd66, 1'b0}, '{8'h00, 1'b0}, '{8'd30, 1'b0}, '{8'h00, 1'b0},
          '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b1},
          '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b1}};
    push_bytes(d);
    gen_bits.delete();
    put_bits(66, 8); put_bits(0, 16); put_ue(0); put_ue(0); put_ue(1);
    put_bits(0, 1); put_ue(0); put_ue(0); put_ue(32'hFFFF_FFFE); put_ue(5);
    d.delete();
    while (gen_bits.size() % 8 != 0) gen_bits.push_back(1'b0);
    for (int i = 0; i < gen_bits.size() / 8; i++) begin
      byte_item_t it;
      for (int k = 0; k < 8; k++) it.data[7 - k] = gen_bits[i * 8 + k];
      it.last = (i == gen_bits.size() / 8 - 1);
      d.push_back(it);
    end
    push_bytes(d);
    lim.low_level = 8'd40;
    lim.high_level = 8'd40;
    queue_sps(3);
    lim.low_level = 8'd0;
    lim.high_level = 8'd255;

    send_idle = 0; recv_idle = 0;
    run_phase(350);
    wait_drained();

    write_reg(REG_EXP_WIDTH, 16'd0);
    write_reg(REG_EXP_HEIGHT, 16'd65535);
    write_reg(REG_EXP_PROFILE, 16'd255);
    write_reg(REG_LOW_LEVEL, 16'd255);
    write_reg(REG_HIGH_LEVEL, 16'd255);
    write_reg(3'd5, 16'hFFFF);
    write_reg(3'd7, 16'h0000);
    send_idle = 73; recv_idle = 0;
    run_phase(350);
    wait_drained();

    write_reg(REG_EXP_WIDTH, 16'd1280);
    write_reg(REG_EXP_HEIGHT, 16'd720);
    write_reg(REG_EXP_PROFILE, 16'd66);
    write_reg(REG_LOW_LEVEL, 16'd20);
    write_reg(REG_HIGH_LEVEL, 16'd51);
    send_idle = 0; recv_idle = 73;
    run_phase(350);
    wait_drained();

    write_reg(REG_EXP_WIDTH, 16'($urandom));
    write_reg(REG_EXP_HEIGHT, 16'($urandom_range(2000)));
    write_reg(REG_EXP_PROFILE, 16'd0);
    write_reg(REG_LOW_LEVEL, 16'd0);
    write_reg(REG_HIGH_LEVEL, 16'd0);
    send_idle = 25; recv_idle = 25;
    run_phase(350);
    wait_drained();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
